FILE: rtl/gte_pkg.sv
// ----------------------------------------------------------------------------
// gte_pkg
// Shared constants and transaction types for the grey threshold erosion unit.
// ----------------------------------------------------------------------------
package gte_pkg;

  localparam int IMG_SIZE = 1024;
  localparam int COL_W    = $clog2(IMG_SIZE);
  localparam int ROW_W    = $clog2(IMG_SIZE + 2);
  localparam int POS_W    = 10;
  localparam int CH_W     = 8;
  localparam int SUM_W    = 10;
  localparam int THR_W    = 10;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(3 * 90 + 3);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 2);

  typedef struct packed {
    logic             white;
    logic [COL_W-1:0] col;
    logic             emit;
  } token_t;

  typedef struct packed {
    logic             pixel_white;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } result_t;

endpackage

FILE: rtl/gte_front.sv
// ----------------------------------------------------------------------------
// gte_front
// Accepts transactions, thresholds the grey level, drops early flushes and
// tracks the stream position of the frame.
// ----------------------------------------------------------------------------
module gte_front import gte_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [CH_W-1:0] cfg_wdata,
  input  logic            in_push,
  output logic            in_full,
  input  logic            in_mode,
  input  logic [CH_W-1:0] in_red,
  input  logic [CH_W-1:0] in_green,
  input  logic [CH_W-1:0] in_blue,
  input  logic            tq_full,
  output logic            tq_push,
  output token_t          tq_data
);

  logic [THR_W-1:0] thr3_r;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [SUM_W-1:0] sum;
  logic             draining;
  logic             accept;

  // grey > t  <=>  r+g+b >= 3t+3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr3_r <= THR_RESET;
    end else if (cfg_we) begin
      thr3_r <= THR_W'({2'b00, cfg_wdata}) + THR_W'({1'b0, cfg_wdata, 1'b0}) + THR_W'(3);
    end
  end

  always_comb begin
    sum      = SUM_W'(in_red) + SUM_W'(in_green) + SUM_W'(in_blue);
    draining = in_row_r >= ROW_W'(IMG_SIZE);
    in_full  = tq_full;
    accept   = in_push && !tq_full;
    tq_push  = accept && (draining || !in_mode);

    tq_data.white = !draining && (sum >= thr3_r);
    tq_data.col   = in_col_r;
    tq_data.emit  = (in_row_r > ROW_W'(1)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));

    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    if (tq_push) begin
      if (in_row_r == ROW_W'(IMG_SIZE + 1)) begin
        in_row_nxt = '0;
        in_col_nxt = '0;
      end else if (in_col_r == COL_W'(IMG_SIZE - 1)) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r <= '0;
      in_col_r <= '0;
    end else begin
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
    end
  end

endmodule

FILE: rtl/gte_token_queue.sv
// ----------------------------------------------------------------------------
// gte_token_queue
// Short queue of classified pixel transactions between front and back.
// ----------------------------------------------------------------------------
module gte_token_queue import gte_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  token_t push_data,
  output logic   full,
  input  logic   pop,
  output token_t pop_data,
  output logic   empty
);

  token_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  always_comb begin
    full     = count_r == QCNT_W'(QDEPTH);
    empty    = count_r == '0;
    do_push  = push && !full;
    do_pop   = pop && !empty;
    pop_data = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/gte_result_queue.sv
// ----------------------------------------------------------------------------
// gte_result_queue
// Output queue of eroded pixel transactions, with occupancy for credit.
// ----------------------------------------------------------------------------
module gte_result_queue import gte_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  result_t           push_data,
  input  logic              pop,
  output result_t           pop_data,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  result_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  always_comb begin
    empty    = count_r == '0;
    count    = count_r;
    do_push  = push && (count_r != QCNT_W'(QDEPTH));
    do_pop   = pop && !empty;
    pop_data = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/gte_back.sv
// ----------------------------------------------------------------------------
// gte_back
// Line store, 3x3 window and X-shaped erosion; issues results on credit.
// ----------------------------------------------------------------------------
module gte_back import gte_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tq_empty,
  input  token_t            tq_data,
  output logic              tq_pop,
  input  logic [QCNT_W-1:0] rq_count,
  output logic              rq_push,
  output result_t           rq_data
);

  logic [1:0]       line_mem [IMG_SIZE];
  logic [1:0]       rd_r;
  logic             a_valid_r;
  token_t           a_tok_r;
  logic [8:0]       win_r;
  logic [COL_W-1:0] emit_row_r, emit_row_nxt;
  logic [COL_W-1:0] emit_col_r, emit_col_nxt;
  logic [2:0]       r0, r1, r2;
  logic             white;
  logic             last;

  // hold back while the result queue could overflow
  assign tq_pop = !tq_empty && ((rq_count + QCNT_W'(a_valid_r)) < QCNT_W'(QDEPTH));

  // bit 1 of each line store entry: two rows up, bit 0: one row up
  always_ff @(posedge clk) begin
    if (tq_pop) begin
      rd_r <= line_mem[tq_data.col];
    end
    if (a_valid_r) begin
      line_mem[a_tok_r.col] <= {rd_r[0], a_tok_r.white};
    end
  end

  always_ff @(posedge clk) begin
    if (tq_pop) begin
      a_tok_r <= tq_data;
    end
    if (a_valid_r) begin
      win_r <= {r2, r1, r0};
    end
  end

  always_comb begin
    r0 = {win_r[1:0], rd_r[1]};
    r1 = {win_r[4:3], rd_r[0]};
    r2 = {win_r[7:6], a_tok_r.white};

    white = r1[1];
    if (emit_row_r != '0) begin
      if (emit_col_r != '0)                   white = white & r0[2];
      if (emit_col_r != COL_W'(IMG_SIZE - 1)) white = white & r0[0];
    end
    if (emit_row_r != COL_W'(IMG_SIZE - 1)) begin
      if (emit_col_r != '0)                   white = white & r2[2];
      if (emit_col_r != COL_W'(IMG_SIZE - 1)) white = white & r2[0];
    end
    last = (emit_row_r == COL_W'(IMG_SIZE - 1)) && (emit_col_r == COL_W'(IMG_SIZE - 1));

    rq_push             = a_valid_r && a_tok_r.emit;
    rq_data.pixel_white = white;
    rq_data.row         = POS_W'(emit_row_r);
    rq_data.col         = POS_W'(emit_col_r);
    rq_data.last        = last;

    emit_row_nxt = emit_row_r;
    emit_col_nxt = emit_col_r;
    if (rq_push) begin
      if (last) begin
        emit_row_nxt = '0;
        emit_col_nxt = '0;
      end else if (emit_col_r == COL_W'(IMG_SIZE - 1)) begin
        emit_col_nxt = '0;
        emit_row_nxt = emit_row_r + COL_W'(1);
      end else begin
        emit_col_nxt = emit_col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r  <= 1'b0;
      emit_row_r <= '0;
      emit_col_r <= '0;
    end else begin
      a_valid_r  <= tq_pop;
      emit_row_r <= emit_row_nxt;
      emit_col_r <= emit_col_nxt;
    end
  end

endmodule

FILE: rtl/grey_threshold_erosion_unit.sv
// ----------------------------------------------------------------------------
// grey_threshold_erosion_unit
// Grey threshold followed by X-shaped 3x3 binary erosion on a raster stream.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | in_push / in_full  | in_mode, in_red, in_green, in_blue
//  result   | out_pop / out_empty| out_pixel_white, out_row, out_column,
//           |                    | out_frame_last
//  config   | cfg_we             | cfg_wdata (grey threshold)
//
// One transaction per cycle sustained while in_full is low; the line store read
// is registered, and a result passes the token queue and back-stage registers.
// Synchronous active-low reset clears counters and queues; the line store is
// not cleared, as its stale contents never reach a result.
// A stalled result side fills the result queue, then the token queue, and
// then raises in_full.
// ----------------------------------------------------------------------------
module grey_threshold_erosion_unit import gte_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CH_W-1:0]  cfg_wdata,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_mode,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  input  logic             out_pop,
  output logic             out_empty,
  output logic             out_pixel_white,
  output logic [POS_W-1:0] out_row,
  output logic [POS_W-1:0] out_column,
  output logic             out_frame_last
);

  logic              tq_push, tq_full, tq_pop, tq_empty;
  token_t            tq_wdata, tq_rdata;
  logic              rq_push;
  result_t           rq_wdata, rq_rdata;
  logic [QCNT_W-1:0] rq_count;

  gte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_mode   (in_mode),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .tq_full   (tq_full),
    .tq_push   (tq_push),
    .tq_data   (tq_wdata)
  );

  gte_token_queue u_token_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tq_push),
    .push_data (tq_wdata),
    .full      (tq_full),
    .pop       (tq_pop),
    .pop_data  (tq_rdata),
    .empty     (tq_empty)
  );

  gte_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tq_empty (tq_empty),
    .tq_data  (tq_rdata),
    .tq_pop   (tq_pop),
    .rq_count (rq_count),
    .rq_push  (rq_push),
    .rq_data  (rq_wdata)
  );

  gte_result_queue u_result_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rq_push),
    .push_data (rq_wdata),
    .pop       (out_pop),
    .pop_data  (rq_rdata),
    .empty     (out_empty),
    .count     (rq_count)
  );

  assign out_pixel_white = rq_rdata.pixel_white;
  assign out_row         = rq_rdata.row;
  assign out_column      = rq_rdata.col;
  assign out_frame_last  = rq_rdata.last;

endmodule

FILE: test/tb_grey_threshold_erosion_unit.sv
// ----------------------------------------------------------------------------
// tb_grey_threshold_erosion_unit
// Streams RGB pixels through the threshold and erosion unit and checks every
// eroded pixel, with its position and end-of-frame flag, against a predictor
// kept in the bench. The run covers threshold edges, early flushes, the
// start-up rows, idle and stall phases, and a full input stall.
// ----------------------------------------------------------------------------
module tb_grey_threshold_erosion_unit;
  import gte_pkg::*;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;
  localparam logic [CH_W-1:0] THRESHOLD_AT_RESET = 8'd90;
  localparam int PIPE_SETTLE = 8;
  localparam int END_SETTLE = 20;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT = 100_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CH_W-1:0] cfg_wdata = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_mode = 1'b0;
  logic [CH_W-1:0] in_red = '0;
  logic [CH_W-1:0] in_green = '0;
  logic [CH_W-1:0] in_blue = '0;
  logic out_pop = 1'b0;
  logic out_empty;
  logic out_pixel_white;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_column;
  logic out_frame_last;

  logic recent_row_bits [IMG_SIZE];
  logic older_row_bits [IMG_SIZE];
  logic [2:0] win_top;
  logic [2:0] win_mid;
  logic [2:0] win_bot;
  int unsigned feed_row;
  int unsigned feed_col;
  int unsigned emit_row;
  int unsigned emit_col;
  logic [CH_W-1:0] grey_thr;
  int results_predicted = 0;
  result_t expected_pixels[$];
  result_t popped_pixel;

  int errors = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int bright_pct = 85;
  int flush_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;

  grey_threshold_erosion_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_mode        (in_mode),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_pixel_white(out_pixel_white),
    .out_row        (out_row),
    .out_column     (out_column),
    .out_frame_last (out_frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: expected no transaction, got white=%0d row=%0d col=%0d last=%0d",
                   $time, out_pixel_white, out_row, out_column, out_frame_last);
        end else begin
          popped_pixel = expected_pixels.pop_front();
          if (out_pixel_white !== popped_pixel.pixel_white || out_row !== popped_pixel.row ||
              out_column !== popped_pixel.col || out_frame_last !== popped_pixel.last) begin
            errors++;
            $display("%0t: expected white=%0d row=%0d col=%0d last=%0d, got %0d %0d %0d %0d",
                     $time, popped_pixel.pixel_white, popped_pixel.row, popped_pixel.col,
                     popped_pixel.last, out_pixel_white, out_row, out_column,
                     out_frame_last);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  task automatic predict_erosion(input logic mode, input logic [CH_W-1:0] r, g, b);
    logic bit_now;
    logic top_bit;
    logic mid_bit;
    logic white;
    logic frame_end;
    int unsigned col;
    int unsigned pos;
    result_t res;
    bit_now = 1'b0;
    // drop a flush while pixels of the frame are still due
    if (!(feed_row < IMG_SIZE && mode == MODE_FLUSH)) begin
      if (feed_row < IMG_SIZE)
        bit_now = ((int'(r) + int'(g) + int'(b)) / 3) > int'(grey_thr);
      col = feed_col;
      top_bit = older_row_bits[col];
      mid_bit = recent_row_bits[col];
      older_row_bits[col] = mid_bit;
      recent_row_bits[col] = bit_now;
      win_top = {win_top[1:0], top_bit};
      win_mid = {win_mid[1:0], mid_bit};
      win_bot = {win_bot[1:0], bit_now};
      pos = feed_row * IMG_SIZE + col;
      feed_col++;
      if (feed_col >= IMG_SIZE) begin
        feed_col = 0;
        feed_row++;
      end
      if (pos >= IMG_SIZE + 1) begin
        white = win_mid[1];
        if (emit_row > 0) begin
          if (emit_col > 0) white &= win_top[2];
          if (emit_col < IMG_SIZE - 1) white &= win_top[0];
        end
        if (emit_row < IMG_SIZE - 1) begin
          if (emit_col > 0) white &= win_bot[2];
          if (emit_col < IMG_SIZE - 1) white &= win_bot[0];
        end
        frame_end = (emit_row == IMG_SIZE - 1) && (emit_col == IMG_SIZE - 1);
        res.pixel_white = white;
        res.row = POS_W'(emit_row);
        res.col = POS_W'(emit_col);
        res.last = frame_end;
        expected_pixels.push_back(res);
        results_predicted++;
        if (frame_end) begin
          feed_row = 0;
          feed_col = 0;
          emit_row = 0;
          emit_col = 0;
          win_top = '0;
          win_mid = '0;
          win_bot = '0;
        end else begin
          emit_col++;
          if (emit_col >= IMG_SIZE) begin
            emit_col = 0;
            emit_row++;
          end
        end
      end
    end
  endtask

  task automatic send_item(input logic mode, input logic [CH_W-1:0] r, g, b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_mode <= mode;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_erosion(mode, r, g, b);
  endtask

  // pick random channels, or a grey level on one side of the threshold split as 3*level+0..2
  task automatic random_colour(output logic [CH_W-1:0] r, g, b);
    int lvl;
    int s;
    int x;
    int y;
    if ($urandom_range(99) < 15) begin
      r = CH_W'($urandom);
      g = CH_W'($urandom);
      b = CH_W'($urandom);
    end else begin
      if ($urandom_range(99) < bright_pct && grey_thr != 8'd255)
        lvl = $urandom_range(255, int'(grey_thr) + 1);
      else
        lvl = $urandom_range(int'(grey_thr), 0);
      s = 3 * lvl + $urandom_range(2);
      if (s > 765) s = 765;
      x = $urandom_range(s < 255 ? s : 255, s > 510 ? s - 510 : 0);
      s = s - x;
      y = $urandom_range(s < 255 ? s : 255, s > 255 ? s - 255 : 0);
      r = CH_W'(x);
      g = CH_W'(y);
      b = CH_W'(s - y);
    end
  endtask

  task automatic send_random_pixel();
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    if ($urandom_range(99) < flush_pct)
      send_item(MODE_FLUSH, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    random_colour(r, g, b);
    send_item(MODE_PIXEL, r, g, b);
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    pop_stall_pct = stall_pct;
  endtask

  task automatic wait_results_done();
    in_push <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CH_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    grey_thr = value;
    cfg_we <= 1'b0;
  endtask

  // threshold at its reset value, channel extremes and early flushes on row 0
  task automatic test_directed_row();
    set_idling(0, 0);
    send_item(MODE_PIXEL, 8'd0, 8'd0, 8'd0);
    send_item(MODE_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(MODE_PIXEL, 8'd90, 8'd91, 8'd91);
    send_item(MODE_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(MODE_PIXEL, 8'd91, 8'd91, 8'd91);
    send_item(MODE_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(MODE_PIXEL, 8'd255, 8'd0, 8'd0);
    send_item(MODE_PIXEL, 8'd0, 8'd255, 8'd0);
    send_item(MODE_PIXEL, 8'd0, 8'd0, 8'd255);
    send_item(MODE_FLUSH, 8'd255, 8'd255, 8'd255);
    send_item(MODE_PIXEL, 8'd255, 8'd255, 8'd0);
    send_item(MODE_PIXEL, 8'd0, 8'd255, 8'd255);
    send_item(MODE_PIXEL, 8'd255, 8'd0, 8'd255);
    send_item(MODE_FLUSH, 8'd0, 8'd0, 8'd0);
    send_item(MODE_PIXEL, 8'hAA, 8'h55, 8'hFF);
    send_item(MODE_PIXEL, 8'h55, 8'hAA, 8'h00);
    send_item(MODE_PIXEL, 8'd90, 8'd90, 8'd92);
    send_item(MODE_PIXEL, 8'd92, 8'd92, 8'd92);
    send_item(MODE_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(MODE_PIXEL, 8'd255, 8'd255, 8'd255);
  endtask

  // fill the start-up rows until results begin to flow
  task automatic test_start_up();
    set_idling(30, 30);
    bright_pct = 90;
    flush_pct = 4;
    while (results_predicted < 60) send_random_pixel();
  endtask

  task automatic test_idle_phases();
    bright_pct = 85;
    for (int phase = 0; phase < 4; phase++) begin
      wait_results_done();
      case (phase)
        0: begin
          write_threshold(8'd0);
          set_idling(0, 0);
        end
        1: begin
          write_threshold(8'd255);
          set_idling(63, 0);
        end
        2: begin
          write_threshold(8'($urandom_range(200, 40)));
          set_idling(0, 63);
        end
        default: begin
          write_threshold(THRESHOLD_AT_RESET);
          set_idling(11, 11);
        end
      endcase
      repeat (50) send_random_pixel();
    end
  endtask

  // hold the result side so the block fills and raises in_full
  task automatic test_backpressure();
    wait_results_done();
    set_idling(0, 0);
    hold_cycles <= HOLD_OFF_CYCLES;
    repeat (60) send_random_pixel();
    wait_results_done();
  endtask

  initial begin
    for (int i = 0; i < IMG_SIZE; i++) begin
      recent_row_bits[i] = 1'b0;
      older_row_bits[i] = 1'b0;
    end
    win_top = '0;
    win_mid = '0;
    win_bot = '0;
    feed_row = 0;
    feed_col = 0;
    emit_row = 0;
    emit_col = 0;
    grey_thr = THRESHOLD_AT_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_row();
    test_start_up();
    test_idle_phases();
    test_backpressure();
    repeat (END_SETTLE) @(posedge clk);
    if (errors == 0 && expected_pixels.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
rtl/gte_pkg.sv
rtl/gte_front.sv
rtl/gte_token_queue.sv
rtl/gte_result_queue.sv
rtl/gte_back.sv
rtl/grey_threshold_erosion_unit.sv
test/tb_grey_threshold_erosion_unit.sv
